// ----- hdl/utf8_byte_stream_decoder_core_macros.svh -----
// assertion macros for the utf8 byte stream decoder
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define UTF8_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("utf8 decoder check failed");
// condition implies consequence in the next cycle
`define UTF8_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("utf8 decoder check failed");
`else
`define UTF8_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define UTF8_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

// ----- hdl/utf8dec_pkg.sv -----
package utf8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEAD_W = 5;
    localparam int REM_W  = 2;
    localparam int CONT_W = 6;

    // lead byte classification masks and match patterns
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_PAY  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_PAY  = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_PAY  = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_PAY   = 8'h3F;

    // continuation bytes still expected after each lead kind
    localparam logic [REM_W-1:0] REM_NONE = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0]   acc;
        logic [LEAD_W-1:0] lead;
        logic [REM_W-1:0]  rem;
    } dec_state_t;

    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic              cut_short;
        logic              string_end;
    } dec_result_t;

endpackage

// ----- hdl/utf8_byte_stream_decoder_core.sv -----
// UTF-8 byte stream decoder. Bytes enter one per item on the byte channel, with
// last_byte marking the final byte of a string; each completed sequence leaves as
// one code point item on the cp channel. Lead bytes 0x00-0x7F, 110xxxxx, 1110xxxx
// and 11110xxx open sequences of one to four bytes; the bytes that follow are taken
// as continuations without checking and their low six bits are shifted in. A byte
// that is not a valid lead byte while a lead is expected is dropped with no output.
// If a string ends inside a sequence, one item carries only the lead byte's payload
// bits with cut_short and string_end set, and decoding restarts clean for the next
// string. Throughput is one byte per clock while byte_stall is low: a byte is
// captured in an input register, decoded by a single combinational step against
// the sequence state, and the result lands in an output register. The input
// register can still take one byte while a finished code point waits, and
// byte_stall rises only when both registers hold items and cp_stall is high.
`include "utf8_byte_stream_decoder_core_macros.svh"

module utf8_byte_stream_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_stall,
    input  logic [utf8dec_pkg::BYTE_W-1:0] data_byte,
    input  logic                           last_byte,
    output logic                           cp_valid,
    input  logic                           cp_stall,
    output logic [utf8dec_pkg::CP_W-1:0]   code_point,
    output logic                           cut_short,
    output logic                           string_end
);
    import utf8dec_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // sequence state
    dec_state_t        state_reg, state_next;

    // output register
    logic              cp_valid_reg, cp_valid_next;
    logic [CP_W-1:0]   code_point_reg;
    logic              cut_short_reg;
    logic              string_end_reg;

    dec_result_t       step_result;
    logic              take_byte;
    logic              advance;

    // the held byte moves on when the output slot is free or being emptied
    assign advance    = in_valid_reg && (!cp_valid_reg || !cp_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign take_byte  = byte_valid && !byte_stall;

    utf8dec_step u_step (
        .state      (state_reg),
        .data_byte  (byte_reg),
        .last_byte  (last_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb
    begin
        if (take_byte)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // an advancing byte that makes no code point still clears a drained slot
    always_comb
    begin
        if (advance)
        begin
            cp_valid_next = step_result.emit;
        end
        else if (cp_valid_reg && !cp_stall)
        begin
            cp_valid_next = 1'b0;
        end
        else
        begin
            cp_valid_next = cp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cp_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cp_valid_reg <= cp_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (advance && step_result.emit)
        begin
            code_point_reg <= step_result.code_point;
            cut_short_reg  <= step_result.cut_short;
            string_end_reg <= step_result.string_end;
        end
    end

    assign cp_valid   = cp_valid_reg;
    assign code_point = code_point_reg;
    assign cut_short  = cut_short_reg;
    assign string_end = string_end_reg;

    // a truncated sequence is always reported at a string end
    `UTF8_ASSERT_SAME(a_cut_at_end, clk, rst_n, cp_valid_reg && cut_short_reg, string_end_reg)
    // a truncated result carries only lead payload bits
    `UTF8_ASSERT_SAME(a_cut_narrow, clk, rst_n, cp_valid_reg && cut_short_reg,
                      code_point_reg[CP_W-1:LEAD_W] == '0)
    // the final byte of a string always leaves the decoder expecting a lead
    `UTF8_ASSERT_NEXT(a_end_clean, clk, rst_n, advance && last_reg, state_reg.rem == REM_NONE)
    // backpressure only while a byte is held
    `UTF8_ASSERT_SAME(a_stall_held, clk, rst_n, byte_stall, in_valid_reg && cp_valid_reg)

endmodule

// ----- hdl/utf8dec_step.sv -----
module utf8dec_step (
    input  utf8dec_pkg::dec_state_t        state,
    input  logic [utf8dec_pkg::BYTE_W-1:0] data_byte,
    input  logic                           last_byte,
    output utf8dec_pkg::dec_state_t        state_next,
    output utf8dec_pkg::dec_result_t       result
);
    import utf8dec_pkg::*;

    logic [CP_W-1:0]   acc_shift;
    logic [REM_W-1:0]  rem_dec;
    logic [BYTE_W-1:0] cont_bits;

    assign cont_bits = data_byte & CONT_PAY;
    assign acc_shift = {state.acc[CP_W-CONT_W-1:0], cont_bits[CONT_W-1:0]};
    assign rem_dec   = state.rem - REM_ONE;

    always_comb
    begin
        logic [BYTE_W-1:0] pay;
        logic [REM_W-1:0]  need;
        logic              is_lead;

        pay        = '0;
        need       = REM_NONE;
        is_lead    = 1'b0;
        state_next = state;
        result     = '0;

        if (state.rem == REM_NONE)
        begin
            if (data_byte <= ASCII_MAX)
            begin
                result.emit       = 1'b1;
                result.code_point = {{(CP_W-BYTE_W){1'b0}}, data_byte};
                result.string_end = last_byte;
            end
            else
            begin
                if ((data_byte & LEAD2_MASK) == LEAD2_PAT)
                begin
                    pay     = data_byte & LEAD2_PAY;
                    need    = REM_ONE;
                    is_lead = 1'b1;
                end
                else if ((data_byte & LEAD3_MASK) == LEAD3_PAT)
                begin
                    pay     = data_byte & LEAD3_PAY;
                    need    = REM_TWO;
                    is_lead = 1'b1;
                end
                else if ((data_byte & LEAD4_MASK) == LEAD4_PAT)
                begin
                    pay     = data_byte & LEAD4_PAY;
                    need    = REM_THREE;
                    is_lead = 1'b1;
                end

                // invalid lead leaves everything as it was
                if (is_lead)
                begin
                    if (last_byte)
                    begin
                        state_next        = '0;
                        result.emit       = 1'b1;
                        result.code_point = {{(CP_W-LEAD_W){1'b0}}, pay[LEAD_W-1:0]};
                        result.cut_short  = 1'b1;
                        result.string_end = 1'b1;
                    end
                    else
                    begin
                        state_next.lead = pay[LEAD_W-1:0];
                        state_next.acc  = {{(CP_W-LEAD_W){1'b0}}, pay[LEAD_W-1:0]};
                        state_next.rem  = need;
                    end
                end
            end
        end
        else if (rem_dec == REM_NONE)
        begin
            state_next        = '0;
            result.emit       = 1'b1;
            result.code_point = acc_shift;
            result.string_end = last_byte;
        end
        else if (last_byte)
        begin
            // partial continuation bits are dropped
            state_next        = '0;
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-LEAD_W){1'b0}}, state.lead};
            result.cut_short  = 1'b1;
            result.string_end = 1'b1;
        end
        else
        begin
            state_next.acc = acc_shift;
            state_next.rem = rem_dec;
        end
    end

endmodule
